### design/cqkp_pkg.sv
package cqkp_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int FUNC_W    = 2;
   localparam int KEY_W     = 64;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 4;
   localparam int SERVED_W  = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_ENQUEUE = 2'd1,
      FUNC_DEQUEUE = 2'd2,
      FUNC_FIND    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

endpackage

### design/circular_queue_with_key_position_core.sv
// channel   ports                                                   direction
// req       req_valid req_ready req_func req_key_in req_payload_in   in
// rsp       rsp_valid rsp_ready rsp_status rsp_key_out rsp_payload_out
//           rsp_ahead_count rsp_occupancy rsp_served_total          out
//
// clear, enqueue, dequeue and a lookup on an empty queue pass through the exec state
// a lookup on a non-empty queue reads the entries from the head, one at a time, until
// the match or the last entry, through the single read port of the key memory
// reset (synchronous) empties the queue and zeroes the served counter
// a beat is accepted only in idle; a finished result waits in the rsp register
// and the next beat may be accepted while it waits
module circular_queue_with_key_position_core #(
   parameter int DEPTH = cqkp_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cqkp_pkg::FUNC_W-1:0]       req_func,
   input  logic [cqkp_pkg::KEY_W-1:0]        req_key_in,
   input  logic [cqkp_pkg::PAYLOAD_W-1:0]    req_payload_in,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cqkp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cqkp_pkg::KEY_W-1:0]        rsp_key_out,
   output logic [cqkp_pkg::PAYLOAD_W-1:0]    rsp_payload_out,
   output logic [cqkp_pkg::COUNT_W-1:0]      rsp_ahead_count,
   output logic [cqkp_pkg::COUNT_W-1:0]      rsp_occupancy,
   output logic [cqkp_pkg::SERVED_W-1:0]     rsp_served_total
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam int CW = cqkp_pkg::COUNT_W;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   // memories
   logic [cqkp_pkg::KEY_W-1:0]     key_mem     [DEPTH];
   logic [cqkp_pkg::PAYLOAD_W-1:0] payload_mem [DEPTH];

   logic                           rd_en;
   logic [PW-1:0]                  rd_addr;
   logic [cqkp_pkg::KEY_W-1:0]     rd_key_ff;
   logic [cqkp_pkg::PAYLOAD_W-1:0] rd_payload_ff;
   logic                           wr_en;

   // control and state
   cqkp_pkg::state_type            state_ff, state_in;
   logic [PW-1:0]                  head_ff, head_in;
   logic [PW-1:0]                  tail_ff, tail_in;
   logic [PW-1:0]                  count_ff, count_in;
   logic [cqkp_pkg::SERVED_W-1:0]  served_ff, served_in;
   logic [PW-1:0]                  cnt_ff, cnt_in;
   logic [PW-1:0]                  scan_ptr_ff, scan_ptr_in;

   cqkp_pkg::func_type             op_func_ff, op_func_in;
   logic [cqkp_pkg::KEY_W-1:0]     op_key_ff, op_key_in;
   logic [cqkp_pkg::PAYLOAD_W-1:0] op_payload_ff, op_payload_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   cqkp_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [cqkp_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [cqkp_pkg::PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic [CW-1:0]                  rsp_ahead_ff, rsp_ahead_in;
   logic [CW-1:0]                  rsp_occ_ff, rsp_occ_in;
   logic [cqkp_pkg::SERVED_W-1:0]  rsp_served_ff, rsp_served_in;

   logic                           accept;
   logic                           out_free;
   logic                           commit;
   logic                           advance;
   logic                           is_full;
   logic                           is_empty;
   logic                           key_match;
   logic                           scan_last;
   logic                           scan_done;
   logic [PW+CW-1:0]               ahead_wide;
   logic [PW+CW-1:0]               occ_wide;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == LAST);
   assign is_empty  = (count_ff == '0);
   assign key_match = (rd_key_ff == op_key_ff);
   assign scan_last = (cnt_ff == count_ff - 1'b1);
   assign scan_done = key_match || scan_last;
   assign ahead_wide = {{CW{1'b0}}, cnt_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cqkp_pkg::ST_IDLE: begin
            if (accept) begin
               if (cqkp_pkg::func_type'(req_func) == cqkp_pkg::FUNC_FIND && !is_empty) begin
                  state_in = cqkp_pkg::ST_SCAN;
               end else begin
                  state_in = cqkp_pkg::ST_EXEC;
               end
            end
         end
         cqkp_pkg::ST_EXEC: begin
            if (commit) begin
               state_in = cqkp_pkg::ST_IDLE;
            end
         end
         cqkp_pkg::ST_SCAN: begin
            if (commit) begin
               state_in = cqkp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cqkp_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      commit    = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         cqkp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_en     = 1'b1;
         end
         cqkp_pkg::ST_EXEC: begin
            commit = out_free;
         end
         cqkp_pkg::ST_SCAN: begin
            rd_addr = scan_ptr_ff;
            advance = !scan_done;
            rd_en   = !scan_done;
            commit  = scan_done && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign wr_en = commit && (state_ff == cqkp_pkg::ST_EXEC)
                  && (op_func_ff == cqkp_pkg::FUNC_ENQUEUE) && !is_full;

   // datapath
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      served_in      = served_ff;
      cnt_in         = cnt_ff;
      scan_ptr_in    = scan_ptr_ff;
      op_func_in     = op_func_ff;
      op_key_in      = op_key_ff;
      op_payload_in  = op_payload_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_ahead_in   = rsp_ahead_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_served_in  = rsp_served_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      occ_wide       = '0;

      if (accept) begin
         op_func_in    = cqkp_pkg::func_type'(req_func);
         op_key_in     = req_key_in;
         op_payload_in = req_payload_in;
         cnt_in        = '0;
         scan_ptr_in   = next_slot(head_ff);
      end

      if (advance) begin
         cnt_in      = cnt_ff + 1'b1;
         scan_ptr_in = next_slot(scan_ptr_ff);
      end

      if (commit) begin
         rsp_status_in  = cqkp_pkg::STATUS_OK;
         rsp_key_in     = '0;
         rsp_payload_in = '0;
         rsp_ahead_in   = '0;
         if (state_ff == cqkp_pkg::ST_SCAN) begin
            if (key_match) begin
               rsp_ahead_in = ahead_wide[CW-1:0];
            end else begin
               rsp_status_in = cqkp_pkg::STATUS_NOT_FOUND;
            end
         end else begin
            unique case (op_func_ff)
               cqkp_pkg::FUNC_CLEAR: begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end
               cqkp_pkg::FUNC_ENQUEUE: begin
                  if (is_full) begin
                     rsp_status_in = cqkp_pkg::STATUS_FULL;
                  end else begin
                     tail_in  = next_slot(tail_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               cqkp_pkg::FUNC_DEQUEUE: begin
                  if (is_empty) begin
                     rsp_status_in = cqkp_pkg::STATUS_EMPTY;
                  end else begin
                     rsp_key_in     = rd_key_ff;
                     rsp_payload_in = rd_payload_ff;
                     head_in        = next_slot(head_ff);
                     count_in       = count_ff - 1'b1;
                     served_in      = served_ff + 1'b1;
                  end
               end
               cqkp_pkg::FUNC_FIND: begin
                  rsp_status_in = cqkp_pkg::STATUS_EMPTY;
               end
               default: begin
                  rsp_status_in = cqkp_pkg::STATUS_OK;
               end
            endcase
         end
         occ_wide      = {{CW{1'b0}}, count_in};
         rsp_occ_in    = occ_wide[CW-1:0];
         rsp_served_in = served_in;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cqkp_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         served_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         served_ff    <= served_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      scan_ptr_ff    <= scan_ptr_in;
      op_func_ff     <= op_func_in;
      op_key_ff      <= op_key_in;
      op_payload_ff  <= op_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_ahead_ff   <= rsp_ahead_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_served_ff  <= rsp_served_in;
   end

   // entry memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[tail_ff]     <= op_key_ff;
         payload_mem[tail_ff] <= op_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff     <= key_mem[rd_addr];
         rd_payload_ff <= payload_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_payload_out  = rsp_payload_ff;
   assign rsp_ahead_count  = rsp_ahead_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_served_total = rsp_served_ff;

   // pointer distance must agree with the entry count
   logic [PW:0] ptr_dist;

   always_comb begin
      ptr_dist = {1'b0, tail_ff} - {1'b0, head_ff};
      if (tail_ff < head_ff) begin
         ptr_dist = ptr_dist + (PW+1)'(DEPTH);
      end
   end

   a_count_matches_ptrs: assert property (@(posedge clock) disable iff (reset)
      ptr_dist[PW-1:0] == count_ff)
      else $error("entry count does not match head and tail");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff != LAST))
      else $error("memory write while queue full");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cqkp_pkg::ST_SCAN) |-> (cnt_ff < count_ff))
      else $error("lookup walked past the tail");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != cqkp_pkg::ST_IDLE))
      else $error("result beat raised without an operation in flight");

   a_served_on_dequeue: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && served_ff != $past(served_ff))
         |-> (rsp_valid_ff && rsp_status_ff == cqkp_pkg::STATUS_OK
              && $past(op_func_ff) == cqkp_pkg::FUNC_DEQUEUE))
      else $error("served counter moved without a successful dequeue");

endmodule

### tb/sv/circular_queue_with_key_position_core_test.sv
`timescale 1ns / 100ps

module circular_queue_with_key_position_core_test;

   localparam int DEPTH = cqkp_pkg::DEPTH_DEFAULT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int HOLD_CYCLES = 80;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 100;

   typedef struct packed {
      cqkp_pkg::func_type                   func;
      logic [cqkp_pkg::KEY_W-1:0]           key;
      logic [cqkp_pkg::PAYLOAD_W-1:0]       payload;
   } queue_command_type;

   typedef struct packed {
      cqkp_pkg::status_type                 status;
      logic [cqkp_pkg::KEY_W-1:0]           key;
      logic [cqkp_pkg::PAYLOAD_W-1:0]       payload;
      logic [cqkp_pkg::COUNT_W-1:0]         ahead;
      logic [cqkp_pkg::COUNT_W-1:0]         occupancy;
      logic [cqkp_pkg::SERVED_W-1:0]        served;
   } queue_outcome_type;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [cqkp_pkg::FUNC_W-1:0]          req_func = '0;
   logic [cqkp_pkg::KEY_W-1:0]           req_key_in = '0;
   logic [cqkp_pkg::PAYLOAD_W-1:0]       req_payload_in = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [cqkp_pkg::STATUS_W-1:0]        rsp_status;
   logic [cqkp_pkg::KEY_W-1:0]           rsp_key_out;
   logic [cqkp_pkg::PAYLOAD_W-1:0]       rsp_payload_out;
   logic [cqkp_pkg::COUNT_W-1:0]         rsp_ahead_count;
   logic [cqkp_pkg::COUNT_W-1:0]         rsp_occupancy;
   logic [cqkp_pkg::SERVED_W-1:0]        rsp_served_total;

   // shadow of the ring buffer
   logic [cqkp_pkg::KEY_W-1:0]           q_keys [DEPTH];
   logic [cqkp_pkg::PAYLOAD_W-1:0]       q_payloads [DEPTH];
   logic [IDX_W-1:0]                     q_head = '0;
   logic [IDX_W-1:0]                     q_tail = '0;
   logic [cqkp_pkg::SERVED_W-1:0]        q_served = '0;

   queue_command_type                    command_backlog[$];
   queue_outcome_type                    pending_outcomes[$];
   logic [cqkp_pkg::KEY_W-1:0]           key_pool [8];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_granted = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int failures = 0;
   int outcomes_checked = 0;
   int deepest_match = 0;
   int status_tally [4] = '{0, 0, 0, 0};
   logic req_taken = 1'b0;

   circular_queue_with_key_position_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_key_in       (req_key_in),
      .req_payload_in   (req_payload_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_key_out      (rsp_key_out),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_ahead_count  (rsp_ahead_count),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_served_total (rsp_served_total)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic queue_outcome_type queue_op_outcome(
         cqkp_pkg::func_type op,
         logic [cqkp_pkg::KEY_W-1:0] key,
         logic [cqkp_pkg::PAYLOAD_W-1:0] payload);
      queue_outcome_type res;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] nxt;
      logic [cqkp_pkg::COUNT_W-1:0] pos;
      bit hit;
      res = '0;
      res.status = cqkp_pkg::STATUS_OK;
      hit = 1'b0;
      pos = '0;
      case (op)
         cqkp_pkg::FUNC_CLEAR: begin
            q_head = '0;
            q_tail = '0;
         end
         cqkp_pkg::FUNC_ENQUEUE: begin
            nxt = q_tail + 1'b1;
            if (nxt == q_head) begin
               res.status = cqkp_pkg::STATUS_FULL;
            end else begin
               q_keys[q_tail] = key;
               q_payloads[q_tail] = payload;
               q_tail = nxt;
            end
         end
         cqkp_pkg::FUNC_DEQUEUE: begin
            if (q_head == q_tail) begin
               res.status = cqkp_pkg::STATUS_EMPTY;
            end else begin
               res.key = q_keys[q_head];
               res.payload = q_payloads[q_head];
               q_head = q_head + 1'b1;
               q_served = q_served + 1'b1;
            end
         end
         cqkp_pkg::FUNC_FIND: begin
            if (q_head == q_tail) begin
               res.status = cqkp_pkg::STATUS_EMPTY;
            end else begin
               res.status = cqkp_pkg::STATUS_NOT_FOUND;
               idx = q_head;
               while (idx != q_tail && !hit) begin
                  if (q_keys[idx] == key) begin
                     hit = 1'b1;
                     res.status = cqkp_pkg::STATUS_OK;
                     res.ahead = pos;
                  end else begin
                     pos = pos + 1'b1;
                     idx = idx + 1'b1;
                  end
               end
            end
         end
      endcase
      res.occupancy = q_tail - q_head;
      res.served = q_served;
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin : req_drive
      queue_command_type nxt_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt_cmd = command_backlog.pop_front();
            req_valid <= 1'b1;
            req_func <= nxt_cmd.func;
            req_key_in <= nxt_cmd.key;
            req_payload_in <= nxt_cmd.payload;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_granted != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_granted <= hold_granted + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin : beat_watch
      queue_outcome_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            want = queue_op_outcome(cqkp_pkg::func_type'(req_func), req_key_in,
                                    req_payload_in);
            pending_outcomes.push_back(want);
            status_tally[want.status] = status_tally[want.status] + 1;
            if (want.status == cqkp_pkg::STATUS_OK &&
                cqkp_pkg::func_type'(req_func) == cqkp_pkg::FUNC_FIND &&
                int'(want.ahead) > deepest_match)
               deepest_match = int'(want.ahead);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result beat with no outstanding command");
               failures++;
            end else begin
               want = pending_outcomes.pop_front();
               outcomes_checked++;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_key_out !== want.key) begin
                  $error("key_out: expected %h, got %h", want.key, rsp_key_out);
                  failures++;
               end
               if (rsp_payload_out !== want.payload) begin
                  $error("payload_out: expected %h, got %h", want.payload, rsp_payload_out);
                  failures++;
               end
               if (rsp_ahead_count !== want.ahead) begin
                  $error("ahead_count: expected %0d, got %0d", want.ahead, rsp_ahead_count);
                  failures++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
                  failures++;
               end
               if (rsp_served_total !== want.served) begin
                  $error("served_total: expected %0d, got %0d", want.served, rsp_served_total);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $error("no beat accepted for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_cmd(cqkp_pkg::func_type op, logic [cqkp_pkg::KEY_W-1:0] key,
                           logic [cqkp_pkg::PAYLOAD_W-1:0] payload);
      queue_command_type cmd;
      cmd.func = op;
      cmd.key = key;
      cmd.payload = payload;
      command_backlog.push_back(cmd);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (command_backlog.size() != 0 || req_valid || pending_outcomes.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // runs alternate between filling and draining so that full and empty both come up
   task automatic push_random_cmds(int count);
      int r;
      int run_left;
      bit filling;
      logic [cqkp_pkg::KEY_W-1:0] key;
      run_left = 0;
      filling = 1'b1;
      for (int k = 0; k < 8; k++)
         key_pool[k] = {$urandom, $urandom};
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            filling = !filling;
            run_left = $urandom_range(40, 20);
         end
         run_left--;
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
         r = $urandom_range(99);
         if (r < 3)
            push_cmd(cqkp_pkg::FUNC_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
         else if (r < (filling ? 60 : 28))
            push_cmd(cqkp_pkg::FUNC_ENQUEUE, key, {$urandom, $urandom});
         else if (r < (filling ? 75 : 68))
            push_cmd(cqkp_pkg::FUNC_DEQUEUE, {$urandom, $urandom}, {$urandom, $urandom});
         else
            push_cmd(cqkp_pkg::FUNC_FIND, key, {$urandom, $urandom});
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, fill to full, lookups at both ends, duplicates, clear
      push_cmd(cqkp_pkg::FUNC_CLEAR, '0, '0);
      push_cmd(cqkp_pkg::FUNC_DEQUEUE, '1, '1);
      push_cmd(cqkp_pkg::FUNC_FIND, '0, '0);
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, '1, '0);
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, '0, '1);
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe);
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, 64'h5a5a_5a5a_a5a5_a5a5, 64'ha5a5_a5a5_5a5a_5a5a);
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, 64'hdead_beef_0000_0001, {$urandom, $urandom});
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, '1, 64'h1111_2222_3333_4444);
      for (int i = 0; i < 8; i++)
         push_cmd(cqkp_pkg::FUNC_ENQUEUE, {$urandom, $urandom}, {$urandom, $urandom});
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      push_cmd(cqkp_pkg::FUNC_ENQUEUE, 64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0);
      push_cmd(cqkp_pkg::FUNC_FIND, 64'h0123_4567_89ab_cdef, '0);
      push_cmd(cqkp_pkg::FUNC_FIND, 64'h3c3c_3c3c_c3c3_c3c3, '0);
      push_cmd(cqkp_pkg::FUNC_FIND, '1, '0);
      push_cmd(cqkp_pkg::FUNC_DEQUEUE, '0, '0);
      push_cmd(cqkp_pkg::FUNC_FIND, '1, '1);
      push_cmd(cqkp_pkg::FUNC_CLEAR, '1, '1);
      push_cmd(cqkp_pkg::FUNC_DEQUEUE, '0, '0);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 53 : (ph == 3) ? 25 : 0;
         rsp_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 25 : 0;
         if (ph == 0)
            hold_requests = hold_requests + 1;
         push_random_cmds(RANDOM_PER_PHASE);
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d expected results never arrived", pending_outcomes.size());
         failures++;
      end
      $display("checked %0d operations over four idle/stall mixes, one long response hold-off",
               outcomes_checked);
      $display("outcomes: ok %0d, full %0d, empty %0d, not found %0d; deepest match %0d",
               status_tally[cqkp_pkg::STATUS_OK], status_tally[cqkp_pkg::STATUS_FULL],
               status_tally[cqkp_pkg::STATUS_EMPTY], status_tally[cqkp_pkg::STATUS_NOT_FOUND],
               deepest_match);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### circular_queue_with_key_position_core.f
design/cqkp_pkg.sv
design/circular_queue_with_key_position_core.sv
tb/sv/circular_queue_with_key_position_core_test.sv
